/* rtl/core/kmp_substring_search_defines.svh */
// ----------------------------------------------------------------------------
// kmp substring search assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_SEARCH_DEFINES_SVH
`define KMP_SUBSTRING_SEARCH_DEFINES_SVH

// condition holds at every clock edge out of reset
`define KMP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define KMP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// request kinds and the per-cycle control word broadcast along the cell chain
// ----------------------------------------------------------------------------
package kmp_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_NONE   = 2'd3
	} kmp_action_t;

	typedef struct packed {
		logic       clear_pat;
		logic       append;
		logic       shift;
		logic       flush;
		logic [7:0] data;
	} kmp_bcast_t;

endpackage

/* rtl/core/kmp_cell.sv */
// ----------------------------------------------------------------------------
// kmp_cell
// one pattern position: holds its byte, a fill flag and a prefix-match flag
// that moves one cell down the chain for every text byte
// ----------------------------------------------------------------------------
module kmp_cell
	import kmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  kmp_bcast_t bcast,
	input  logic       prev_valid,
	input  logic       prev_match,
	input  logic       next_valid,
	output logic       valid,
	output logic       match,
	output logic       hit
);

	logic       valid_q;
	logic       match_q;
	logic [7:0] pat_q;
	logic       match_nxt;

	assign match_nxt = prev_match && valid_q && (pat_q == bcast.data);
	assign hit       = bcast.shift && match_nxt && !next_valid;
	assign valid     = valid_q;
	assign match     = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bcast.clear_pat) begin
			valid_q <= 1'b0;
		end else if (bcast.append && prev_valid && !valid_q) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.append && prev_valid && !valid_q) begin
			pat_q <= bcast.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (bcast.flush) begin
			match_q <= 1'b0;
		end else if (bcast.shift) begin
			match_q <= match_nxt;
		end
	end

endmodule

/* rtl/core/kmp_substring_search.sv */
// ----------------------------------------------------------------------------
// kmp_substring_search
// first-match substring finder over a byte stream, one cell per pattern byte
// ----------------------------------------------------------------------------
// Requests enter on s_axis: tuser picks the kind (clear pattern, append a
// pattern byte, text byte), tdata carries the byte, tlast marks the last text
// byte of a text. Appends fill the cell chain in order; a full chain ignores
// further appends. Every text byte updates the prefix-match flags of all
// cells in the same cycle, so one request is taken per clock while s_axis_tready is high.
// A text gives at most one result on m_axis: tuser is found, tdata the start
// position of the first match (0 when the text ended without one). The
// result is registered and appears the cycle after the text byte that
// causes it; nothing else is delayed.
// The output holds one result. While it is full and m_axis_tready is low,
// s_axis_tready is low too; otherwise requests are taken back to back.
// Reset empties the pattern and the search state and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`include "kmp_substring_search_defines.svh"

module kmp_substring_search
	import kmp_pkg::*;
#(
	parameter int MAX_PATTERN    = 64,
	parameter int POSITION_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [7:0]                                s_axis_tdata,  // data_byte
	input  logic [1:0]                                s_axis_tuser,  // action
	input  logic                                      s_axis_tlast,  // last_of_text
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	output logic [((POSITION_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // match_position
	output logic [0:0]                                m_axis_tuser   // found
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int TW = ((POSITION_WIDTH + 7) / 8) * 8;
	localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

	kmp_action_t               action;
	kmp_bcast_t                bcast;
	logic                      acc;
	logic                      is_text;
	logic                      hit_any;
	logic                      give_found;
	logic                      give_miss;
	logic [CW-1:0]             count_q;
	logic [POSITION_WIDTH-1:0] text_pos_q;
	logic                      done_q;
	logic                      out_valid_q;
	logic                      found_q;
	logic [POSITION_WIDTH-1:0] pos_out_q;
	logic [POSITION_WIDTH-1:0] pos_found;
	logic [MAX_PATTERN-1:0]    valid_vec;
	logic [MAX_PATTERN-1:0]    match_vec;
	logic [MAX_PATTERN-1:0]    hit_vec;

	assign action        = kmp_action_t'(s_axis_tuser);
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign is_text       = acc && (action == ACT_TEXT);

	assign bcast.clear_pat = acc && (action == ACT_CLEAR);
	assign bcast.append    = acc && (action == ACT_APPEND);
	assign bcast.shift     = is_text && !done_q && (count_q != '0);
	assign bcast.flush     = bcast.clear_pat || (is_text && (s_axis_tlast || done_q || hit_any));
	assign bcast.data      = s_axis_tdata;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
			logic pv;
			logic pm;
			logic nv;
			if (gi == 0) begin : g_head
				assign pv = 1'b1;
				assign pm = 1'b1;
			end else begin : g_body
				assign pv = valid_vec[gi-1];
				assign pm = match_vec[gi-1];
			end
			if (gi == MAX_PATTERN - 1) begin : g_tail
				assign nv = 1'b0;
			end else begin : g_next
				assign nv = valid_vec[gi+1];
			end
			kmp_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.bcast      (bcast),
				.prev_valid (pv),
				.prev_match (pm),
				.next_valid (nv),
				.valid      (valid_vec[gi]),
				.match      (match_vec[gi]),
				.hit        (hit_vec[gi])
			);
		end
	endgenerate

	assign hit_any    = |hit_vec;
	assign give_found = is_text && !done_q && ((count_q == '0) || hit_any);
	assign give_miss  = is_text && !done_q && !give_found && s_axis_tlast;

	// start index of the match, pinned at the maximum once the index saturates
	always_comb begin
		if (count_q == '0 || text_pos_q == POS_MAX) begin
			pos_found = text_pos_q;
		end else begin
			pos_found = text_pos_q - POSITION_WIDTH'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (bcast.clear_pat) begin
			count_q <= '0;
		end else if (bcast.append && count_q != CW'(MAX_PATTERN)) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_pos_q <= '0;
			done_q     <= 1'b0;
		end else if (bcast.clear_pat || (is_text && s_axis_tlast)) begin
			text_pos_q <= '0;
			done_q     <= 1'b0;
		end else if (is_text) begin
			if (text_pos_q != POS_MAX) begin
				text_pos_q <= text_pos_q + 1'b1;
			end
			if (give_found) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (give_found || give_miss) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (give_found) begin
			found_q   <= 1'b1;
			pos_out_q <= pos_found;
		end else if (give_miss) begin
			found_q   <= 1'b0;
			pos_out_q <= '0;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = TW'(pos_out_q);
	assign m_axis_tuser[0] = found_q;

	`KMP_ASSERT_ALWAYS(a_count_in_range, count_q <= CW'(MAX_PATTERN), "pattern count overflow")
	`KMP_ASSERT_ALWAYS(a_fill_matches_count, $countones(valid_vec) == int'(count_q), "cell fill mismatch")
	`KMP_ASSERT_IMPLY(a_done_no_match, done_q, match_vec == '0, "match flags live after a find")
	`KMP_ASSERT_IMPLY(a_no_overwrite, out_valid_q && !m_axis_tready, !(give_found || give_miss), "result overwritten")

endmodule
